/* rtl/core/hmfd_pkg.sv */
// Shared types, codes and the CRC-16/X-25 byte step for the HDLC meter frame decoder.
`default_nettype none

package hmfd_pkg;

    // Result status codes
    localparam logic [1:0] STATUS_IDLE    = 2'd0;
    localparam logic [1:0] STATUS_GOOD    = 2'd1;
    localparam logic [1:0] STATUS_BAD_FCS = 2'd2;
    localparam logic [1:0] STATUS_DROP    = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_FLAG_BYTE   = 3'd0;
    localparam logic [2:0] REG_ESCAPE_BYTE = 3'd1;
    localparam logic [2:0] REG_ESCAPE_MASK = 3'd2;
    localparam logic [2:0] REG_FORMAT_TYPE = 3'd3;
    localparam logic [2:0] REG_LLC_BYTES   = 3'd4;

    // Reset values of the configuration registers
    localparam logic [7:0] FLAG_RESET   = 8'h7E;
    localparam logic [7:0] ESCAPE_RESET = 8'h7D;
    localparam logic [7:0] MASK_RESET   = 8'h20;
    localparam logic [7:0] FORMAT_RESET = 8'hA0;
    localparam logic [3:0] LLC_RESET    = 4'd3;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_R = 16'h8408;
    localparam logic [10:0] COUNT_MAX  = 11'd2047;

    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] escape_byte;
        logic [7:0] escape_mask;
        logic [7:0] format_type;
        logic [3:0] llc_header_bytes;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        byte_valid;
        logic [7:0]  stored_byte;
        logic [10:0] byte_index;
        logic [10:0] payload_offset;
        logic [10:0] payload_length;
    } result_t;

    // One byte of reflected CRC-16/X-25
    function automatic logic [15:0] crc_x25_step(input logic [15:0] crc_in,
                                                 input logic [7:0] octet);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, octet};
        for (int k = 0; k < 8; k++) begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY_R) : (crc >> 1);
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/hmfd_parser.sv */
// Frame parser: flag hunt, unescape, header parse, CRC and end-of-frame report per word.
`default_nettype none

module hmfd_parser #(
    parameter int BUFFER_DEPTH = 1024,
    parameter int SYNC_SLACK   = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire logic [7:0]       rx_byte,
    input  wire hmfd_pkg::cfg_t   cfg,
    output hmfd_pkg::result_t     result
);

    // Compare width covers the largest sums against the parameters
    localparam int CW = $clog2(4096 + BUFFER_DEPTH + SYNC_SLACK + 1);

    logic [10:0] byte_count_reg, byte_count_next;
    logic [10:0] frame_len_reg, frame_len_next;
    logic [10:0] dest_len_reg, dest_len_next;
    logic [10:0] src_len_reg, src_len_next;
    logic [11:0] mac_len_reg, mac_len_next;
    logic        esc_reg, esc_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  recent_reg [3];
    logic [7:0]  recent_next [3];

    always_comb begin
        logic [7:0]  b;
        logic        escaped;
        logic        go;
        logic        is_flag;
        logic        drop;
        logic [10:0] c;
        logic [15:0] crc_upd;
        logic [10:0] fl;
        logic [10:0] src_new;
        logic [15:0] fcs_rx;
        logic [CW-1:0] cw;
        logic [CW-1:0] flw;
        logic [12:0] off;
        logic signed [13:0] len;

        byte_count_next = byte_count_reg;
        frame_len_next  = frame_len_reg;
        dest_len_next   = dest_len_reg;
        src_len_next    = src_len_reg;
        mac_len_next    = mac_len_reg;
        esc_next        = esc_reg;
        crc_next        = crc_reg;
        recent_next     = recent_reg;
        result          = '0;

        b       = rx_byte;
        escaped = 1'b0;
        go      = 1'b0;
        drop    = 1'b0;
        c       = byte_count_reg + 11'd1;
        cw      = CW'(c);
        flw     = CW'(frame_len_reg);
        crc_upd = (byte_count_reg >= 11'd4) ?
                  hmfd_pkg::crc_x25_step(crc_reg, recent_reg[2]) : crc_reg;
        src_new = c - 11'd3 - dest_len_reg;
        fcs_rx  = {recent_reg[0], recent_reg[1]};
        off     = 13'd1 + 13'(mac_len_reg) + 13'(cfg.llc_header_bytes);
        len     = $signed({3'b000, frame_len_reg}) - 14'sd2
                  - $signed({10'd0, cfg.llc_header_bytes})
                  - $signed({2'b00, mac_len_reg});

        // Unescape; hunt ignores everything but the flag
        if (step && !(byte_count_reg == 11'd0 && rx_byte != cfg.flag_byte)) begin
            if (esc_reg) begin
                b        = rx_byte ^ cfg.escape_mask;
                escaped  = 1'b1;
                esc_next = 1'b0;
                go       = 1'b1;
            end else if (rx_byte == cfg.escape_byte) begin
                esc_next = 1'b1;
            end else begin
                go = 1'b1;
            end
        end
        is_flag = !escaped && (rx_byte == cfg.flag_byte);
        // Frame length from the format word and the unescaped length word
        fl      = {recent_reg[0][2:0], b};

        if (go) begin
            if (byte_count_reg == hmfd_pkg::COUNT_MAX) begin
                // Counter full: drop without storing
                drop          = 1'b1;
                result.status = hmfd_pkg::STATUS_DROP;
            end else begin
                // Store the word and advance the history and CRC
                crc_next           = crc_upd;
                recent_next[2]     = recent_reg[1];
                recent_next[1]     = recent_reg[0];
                recent_next[0]     = b;
                byte_count_next    = c;
                result.byte_valid  = 1'b1;
                result.stored_byte = b;
                result.byte_index  = byte_count_reg;

                if (c == 11'd1) begin
                    // start flag
                end else if (c == 11'd2) begin
                    if (is_flag) begin
                        // doubled flag restarts the frame
                        byte_count_next   = 11'd1;
                        result.byte_index = '0;
                    end else if (b[7:4] != cfg.format_type[7:4]) begin
                        drop          = 1'b1;
                        result.status = hmfd_pkg::STATUS_DROP;
                    end
                end else if (c == 11'd3) begin
                    frame_len_next = fl;
                    if (CW'(fl) + CW'(2) > CW'(BUFFER_DEPTH)) begin
                        drop          = 1'b1;
                        result.status = hmfd_pkg::STATUS_DROP;
                    end
                end else if (dest_len_reg == 11'd0) begin
                    if (b[0]) begin
                        dest_len_next = c - 11'd3;
                    end
                end else if (src_len_reg == 11'd0) begin
                    if (b[0]) begin
                        src_len_next = src_new;
                        mac_len_next = 12'd5 + {1'b0, src_new} + {1'b0, dest_len_reg};
                    end
                end else if (cw == CW'(mac_len_reg) + CW'(1)) begin
                    // MAC header complete
                end else if (cw == flw + CW'(1)) begin
                    // last word before the end flag
                end else if (cw >= flw + CW'(2)) begin
                    if (is_flag) begin
                        // End flag: report and close the frame
                        drop = 1'b1;
                        if (fcs_rx == (crc_upd ^ hmfd_pkg::CRC_INIT)) begin
                            result.status         = hmfd_pkg::STATUS_GOOD;
                            result.payload_offset = (off > 13'd2047) ?
                                                    11'd2047 : off[10:0];
                            result.payload_length = len[13] ? 11'd0 : len[10:0];
                        end else begin
                            result.status = hmfd_pkg::STATUS_BAD_FCS;
                        end
                    end else if (cw >= flw + CW'(2) + CW'(SYNC_SLACK)) begin
                        drop          = 1'b1;
                        result.status = hmfd_pkg::STATUS_DROP;
                    end
                end
            end
        end

        // Clear the frame on drop or report
        if (drop) begin
            byte_count_next = '0;
            frame_len_next  = '0;
            dest_len_next   = '0;
            src_len_next    = '0;
            mac_len_next    = '0;
            esc_next        = 1'b0;
            crc_next        = hmfd_pkg::CRC_INIT;
            recent_next[0]  = '0;
            recent_next[1]  = '0;
            recent_next[2]  = '0;
        end
    end

    // Hold parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            frame_len_reg  <= '0;
            dest_len_reg   <= '0;
            src_len_reg    <= '0;
            mac_len_reg    <= '0;
            esc_reg        <= 1'b0;
            crc_reg        <= hmfd_pkg::CRC_INIT;
            recent_reg[0]  <= '0;
            recent_reg[1]  <= '0;
            recent_reg[2]  <= '0;
        end else begin
            byte_count_reg <= byte_count_next;
            frame_len_reg  <= frame_len_next;
            dest_len_reg   <= dest_len_next;
            src_len_reg    <= src_len_next;
            mac_len_reg    <= mac_len_next;
            esc_reg        <= esc_next;
            crc_reg        <= crc_next;
            recent_reg     <= recent_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/hdlc_meter_frame_decoder_unit.sv */
// Top level of the HDLC meter frame decoder: config registers, parser and result register.
//
// Usage:
//   Input channel s_*: one raw line byte per word (s_rx_byte, s_valid/s_ready).
//   Result channel m_*: exactly one result word per input word, in order:
//   status, stored byte with its index, and payload offset/length on a good frame.
//   Timing: the result is registered and appears in the cycle after the input word is accepted.
//   Throughput: one word per cycle while results are taken; the CRC byte step
//   and all header compares sit between the parse state and the result register.
//   Stall: a single result register separates the channels; s_ready stays high
//   while that register is empty or being taken, so a stalled receiver holds
//   one result and back-pressures the input.
//   Configuration: cfg_wr_en writes cfg_wr_data to register cfg_wr_index
//   (0 flag, 1 escape, 2 escape mask, 3 format type, 4 LLC header bytes);
//   write only while the block is idle. Other indexes are ignored.
//   Reset (aresetn low, synchronous): parse state cleared, CRC preset to all
//   ones, registers return to 0x7E/0x7D/0x20/0xA0/3, result register emptied.
`default_nettype none

module hdlc_meter_frame_decoder_unit #(
    parameter int BUFFER_DEPTH = 1024,
    parameter int SYNC_SLACK   = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_wr_index,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic             m_byte_valid,
    output logic [7:0]       m_stored_byte,
    output logic [10:0]      m_byte_index,
    output logic [10:0]      m_payload_offset,
    output logic [10:0]      m_payload_length
);

    hmfd_pkg::cfg_t    cfg_reg;
    hmfd_pkg::result_t res;
    hmfd_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic              step;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flag_byte        <= hmfd_pkg::FLAG_RESET;
            cfg_reg.escape_byte      <= hmfd_pkg::ESCAPE_RESET;
            cfg_reg.escape_mask      <= hmfd_pkg::MASK_RESET;
            cfg_reg.format_type      <= hmfd_pkg::FORMAT_RESET;
            cfg_reg.llc_header_bytes <= hmfd_pkg::LLC_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                hmfd_pkg::REG_FLAG_BYTE:   cfg_reg.flag_byte        <= cfg_wr_data;
                hmfd_pkg::REG_ESCAPE_BYTE: cfg_reg.escape_byte      <= cfg_wr_data;
                hmfd_pkg::REG_ESCAPE_MASK: cfg_reg.escape_mask      <= cfg_wr_data;
                hmfd_pkg::REG_FORMAT_TYPE: cfg_reg.format_type      <= cfg_wr_data;
                hmfd_pkg::REG_LLC_BYTES:   cfg_reg.llc_header_bytes <= cfg_wr_data[3:0];
                default: ;
            endcase
        end
    end

    // Accept while the result register is free or draining
    assign s_ready = !out_valid_reg || m_ready;
    assign step    = s_valid && s_ready;

    hmfd_parser #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .SYNC_SLACK   (SYNC_SLACK)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (s_rx_byte),
        .cfg     (cfg_reg),
        .result  (res)
    );

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = out_reg.status;
    assign m_byte_valid     = out_reg.byte_valid;
    assign m_stored_byte    = out_reg.stored_byte;
    assign m_byte_index     = out_reg.byte_index;
    assign m_payload_offset = out_reg.payload_offset;
    assign m_payload_length = out_reg.payload_length;

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the HDLC meter frame decoder: framed, escaped and broken line traffic.
module tb;

    localparam int FRAME_DEPTH = 1024;
    localparam int SLACK_BYTES = 8;
    localparam int CYCLE_LIMIT = 600000;

    // Ways in which a generated frame departs from a clean one
    typedef enum {
        DEFECT_NONE,
        DEFECT_FCS,
        DEFECT_FORMAT,
        DEFECT_OVERSIZE,
        DEFECT_NO_END
    } frame_defect_e;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_wr_index = '0;
    logic [7:0]  cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic        m_byte_valid;
    logic [7:0]  m_stored_byte;
    logic [10:0] m_byte_index;
    logic [10:0] m_payload_offset;
    logic [10:0] m_payload_length;

    // Register copies seen by the decoder model
    logic [7:0] cfg_flag = hmfd_pkg::FLAG_RESET;
    logic [7:0] cfg_esc  = hmfd_pkg::ESCAPE_RESET;
    logic [7:0] cfg_mask = hmfd_pkg::MASK_RESET;
    logic [7:0] cfg_fmt  = hmfd_pkg::FORMAT_RESET;
    logic [3:0] cfg_llc  = hmfd_pkg::LLC_RESET;

    // Parse state of the decoder model
    logic [10:0] fr_count = '0;
    logic [10:0] fr_len = '0;
    logic [10:0] dst_len = '0;
    logic [10:0] src_len_q = '0;
    logic [11:0] mac_len = '0;
    bit          esc_wait = 1'b0;
    bit          clr_wait = 1'b0;
    logic [15:0] fcs_acc = hmfd_pkg::CRC_INIT;
    logic [7:0]  hist [3] = '{8'h00, 8'h00, 8'h00};

    logic [7:0]         line_q [$];
    hmfd_pkg::result_t  awaited_reports [$];
    hmfd_pkg::result_t  got_word;
    hmfd_pkg::result_t  want_word;
    int         mismatches = 0;
    int         cycle_count = 0;
    int         tx_gap = 0;
    int         rx_stall = 0;
    bit         tx_calm = 1'b0;
    bit         rx_calm = 1'b0;

    hdlc_meter_frame_decoder_unit #(
        .BUFFER_DEPTH(FRAME_DEPTH),
        .SYNC_SLACK(SLACK_BYTES)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_rx_byte(s_rx_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_byte_valid(m_byte_valid),
        .m_stored_byte(m_stored_byte),
        .m_byte_index(m_byte_index),
        .m_payload_offset(m_payload_offset),
        .m_payload_length(m_payload_length)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // Reflected CRC-16/X-25, one octet
    function automatic logic [15:0] x25_crc_byte(input logic [15:0] acc, input logic [7:0] octet);
        logic [15:0] v;
        v = acc ^ {8'h00, octet};
        repeat (8) v = v[0] ? ({1'b0, v[15:1]} ^ hmfd_pkg::CRC_POLY_R) : {1'b0, v[15:1]};
        return v;
    endfunction

    function automatic void clear_frame_state();
        fr_count  = '0;
        fr_len    = '0;
        dst_len   = '0;
        src_len_q = '0;
        mac_len   = '0;
        esc_wait  = 1'b0;
        clr_wait  = 1'b0;
        fcs_acc   = hmfd_pkg::CRC_INIT;
        hist[0]   = '0;
        hist[1]   = '0;
        hist[2]   = '0;
    endfunction

    // Decode one line octet and return the result word it produces
    function automatic hmfd_pkg::result_t decode_octet(input logic [7:0] raw);
        hmfd_pkg::result_t r;
        logic [7:0]  b;
        logic [10:0] idx;
        logic [15:0] fcs_rx;
        int          c;
        int          pay;
        int          off;
        bit          escaped;
        bit          is_flag;
        r = '0;
        escaped = 1'b0;
        if (clr_wait) clear_frame_state();
        // hunt for the start flag
        if (fr_count == 0 && raw != cfg_flag) return r;
        if (esc_wait) begin
            b = raw ^ cfg_mask;
            esc_wait = 1'b0;
            escaped = 1'b1;
        end else if (raw == cfg_esc) begin
            esc_wait = 1'b1;
            return r;
        end else begin
            b = raw;
        end
        is_flag = !escaped && raw == cfg_flag;
        // counter full: drop without storing
        if (fr_count >= hmfd_pkg::COUNT_MAX) begin
            clear_frame_state();
            r.status = hmfd_pkg::STATUS_DROP;
            return r;
        end
        idx = fr_count;
        if (idx >= 4) fcs_acc = x25_crc_byte(fcs_acc, hist[2]);
        hist[2] = hist[1];
        hist[1] = hist[0];
        hist[0] = b;
        fr_count = idx + 11'd1;
        c = int'(fr_count);
        r.byte_valid = 1'b1;
        r.stored_byte = b;
        r.byte_index = idx;
        if (c == 1) begin
            // start flag stored
        end else if (c == 2) begin
            if (is_flag) begin
                fr_count = 11'd1;
                r.byte_index = '0;
            end else if (b[7:4] != cfg_fmt[7:4]) begin
                clear_frame_state();
                r.status = hmfd_pkg::STATUS_DROP;
            end
        end else if (c == 3) begin
            fr_len = {hist[1][2:0], hist[0]};
            if (int'(fr_len) + 2 > FRAME_DEPTH) begin
                clear_frame_state();
                r.status = hmfd_pkg::STATUS_DROP;
            end
        end else if (dst_len == 0) begin
            if (b[0]) dst_len = 11'(c - 3);
        end else if (src_len_q == 0) begin
            if (b[0]) begin
                src_len_q = 11'(c - 3 - int'(dst_len));
                mac_len = 12'(5 + int'(src_len_q) + int'(dst_len));
            end
        end else if (c == int'(mac_len) + 1) begin
            // end of MAC header, never an end flag
        end else if (c == int'(fr_len) + 1) begin
            // last octet before the end flag, never an end flag
        end else if (c >= int'(fr_len) + 2) begin
            if (is_flag) begin
                fcs_rx = {hist[1], hist[2]};
                clr_wait = 1'b1;
                if (fcs_rx == ~fcs_acc) begin
                    pay = int'(fr_len) - 2 - int'(cfg_llc) - int'(mac_len);
                    off = 1 + int'(mac_len) + int'(cfg_llc);
                    r.status = hmfd_pkg::STATUS_GOOD;
                    r.payload_offset = off > 2047 ? 11'd2047 : 11'(off);
                    r.payload_length = pay < 0 ? 11'd0 : 11'(pay);
                end else begin
                    r.status = hmfd_pkg::STATUS_BAD_FCS;
                end
            end else if (c >= int'(fr_len) + 2 + SLACK_BYTES) begin
                clear_frame_state();
                r.status = hmfd_pkg::STATUS_DROP;
            end
        end
        return r;
    endfunction

    // Build one frame on the line: addresses, header, body, FCS and flags
    task automatic queue_frame(input int d_n, input int s_n, input int x_n, input int k,
                               input frame_defect_e defect, input bit twin_flag,
                               input bit early_flag);
        logic [7:0]  body [$];
        logic [15:0] acc;
        logic [10:0] flen;
        logic [3:0]  nib;
        logic [7:0]  v;
        int          mac;
        int          total;
        int          mark;
        mac = 5 + d_n + s_n;
        total = mac + x_n + 2;
        flen = 11'(total - k);
        if (defect == DEFECT_OVERSIZE) flen = 11'($urandom_range(1023, 2047));
        nib = cfg_fmt[7:4];
        if (defect == DEFECT_FORMAT) nib = nib + 4'($urandom_range(1, 15));
        body.push_back({nib, 1'($urandom_range(0, 1)), flen[10:8]});
        body.push_back(flen[7:0]);
        for (int i = 0; i < d_n; i++) body.push_back({7'($urandom), i == d_n - 1});
        for (int i = 0; i < s_n; i++) body.push_back({7'($urandom), i == s_n - 1});
        // control, header check, LLC header and payload
        for (int i = 0; i < 3 + x_n; i++) body.push_back(8'($urandom));
        // place an unescaped flag where the decoder must not end the frame
        mark = 0;
        if (early_flag) begin
            mark = mac;
            if (k >= 2 && int'(flen) > 2 + d_n + s_n && int'(flen) <= total - 2
                    && $urandom_range(0, 1) == 1)
                mark = int'(flen);
            body[mark - 1] = cfg_flag;
        end
        acc = hmfd_pkg::CRC_INIT;
        foreach (body[i]) acc = x25_crc_byte(acc, body[i]);
        acc = ~acc;
        if (defect == DEFECT_FCS) acc[$urandom_range(0, 15)] ^= 1'b1;
        body.push_back(acc[7:0]);
        body.push_back(acc[15:8]);
        // emit with escapes
        line_q.push_back(cfg_flag);
        if (twin_flag) line_q.push_back(cfg_flag);
        foreach (body[i]) begin
            if (i + 1 != mark && (body[i] == cfg_flag || body[i] == cfg_esc)) begin
                line_q.push_back(cfg_esc);
                line_q.push_back(body[i] ^ cfg_mask);
            end else begin
                line_q.push_back(body[i]);
            end
        end
        if (defect == DEFECT_NO_END) begin
            repeat (10) begin
                do v = 8'($urandom); while (v == cfg_flag || v == cfg_esc);
                line_q.push_back(v);
            end
        end else begin
            line_q.push_back(cfg_flag);
        end
    endtask

    // Mostly clean frames with random content, some broken, some line noise
    task automatic queue_random_frames(input int target);
        frame_defect_e defect;
        int            pick;
        while (line_q.size() < target) begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom));
            pick = $urandom_range(0, 19);
            if (pick < 13) defect = DEFECT_NONE;
            else if (pick < 15) defect = DEFECT_FCS;
            else if (pick == 15) defect = DEFECT_FORMAT;
            else if (pick == 16) defect = DEFECT_OVERSIZE;
            else defect = DEFECT_NO_END;
            queue_frame($urandom_range(1, 4), $urandom_range(1, 4),
                        $urandom_range(0, 9) == 0 ? $urandom_range(25, 120)
                                                  : $urandom_range(0, 24),
                        $urandom_range(0, 2) == 0 ? $urandom_range(1, 7) : 0,
                        defect, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
        end
    endtask

    // Write all five registers, one per clock, while the decoder is idle
    task automatic apply_settings(input logic [7:0] flag, input logic [7:0] esc,
                                  input logic [7:0] mask, input logic [7:0] fmt,
                                  input logic [3:0] llc);
        logic [7:0] vals [5];
        logic [2:0] regs [5];
        vals = '{flag, esc, mask, fmt, {4'h0, llc}};
        regs = '{hmfd_pkg::REG_FLAG_BYTE, hmfd_pkg::REG_ESCAPE_BYTE,
                 hmfd_pkg::REG_ESCAPE_MASK, hmfd_pkg::REG_FORMAT_TYPE,
                 hmfd_pkg::REG_LLC_BYTES};
        for (int i = 0; i < 5; i++) begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_wr_index <= regs[i];
            cfg_wr_data <= vals[i];
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_flag = flag;
        cfg_esc  = esc;
        cfg_mask = mask;
        cfg_fmt  = fmt;
        cfg_llc  = llc;
    endtask

    // Hold until every queued word went in and every result came back
    task automatic wait_drained();
        while (line_q.size() != 0 || s_valid || awaited_reports.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Present queued line octets; predict each word as it is accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_rx_byte <= '0;
        end else begin
            if (s_valid && s_ready) awaited_reports.push_back(decode_octet(s_rx_byte));
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap = tx_gap - 1;
                    s_valid <= 1'b0;
                end else if (line_q.size() > 0) begin
                    s_valid <= 1'b1;
                    s_rx_byte <= line_q.pop_front();
                    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
                    tx_gap = tx_calm ? 0 : $urandom_range(0, 11);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Take result words with random stalls and compare against the prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got_word.status = m_status;
                got_word.byte_valid = m_byte_valid;
                got_word.stored_byte = m_stored_byte;
                got_word.byte_index = m_byte_index;
                got_word.payload_offset = m_payload_offset;
                got_word.payload_length = m_payload_length;
                if (awaited_reports.size() == 0) begin
                    $display("%0t: unexpected result word status=%0d byte=%02h index=%0d",
                             $time, m_status, m_stored_byte, m_byte_index);
                    mismatches++;
                end else begin
                    want_word = awaited_reports.pop_front();
                    if (got_word !== want_word) begin
                        $display({"%0t: mismatch expected st=%0d v=%0d b=%02h i=%0d off=%0d",
                                  " len=%0d got st=%0d v=%0d b=%02h i=%0d off=%0d len=%0d"},
                                 $time, want_word.status, want_word.byte_valid,
                                 want_word.stored_byte, want_word.byte_index,
                                 want_word.payload_offset, want_word.payload_length,
                                 got_word.status, got_word.byte_valid, got_word.stored_byte,
                                 got_word.byte_index, got_word.payload_offset,
                                 got_word.payload_length);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
                rx_stall = rx_calm ? 0 : $urandom_range(0, 11);
            end
            if (rx_stall > 0) begin
                rx_stall = rx_stall - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Give up on a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [7:0] fill;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: noise while hunting, a doubled start flag on a short frame
        // whose payload length goes negative, then a bad format nibble
        line_q.push_back(8'h00);
        line_q.push_back(8'hFF);
        line_q.push_back(hmfd_pkg::ESCAPE_RESET);
        queue_frame(1, 1, 0, 0, DEFECT_NONE, 1'b1, 1'b0);
        queue_frame(1, 1, 0, 0, DEFECT_FORMAT, 1'b0, 1'b0);
        queue_random_frames(170);
        wait_drained();

        // Random settings, flag and escape kept apart
        fill = 8'($urandom);
        apply_settings(fill, fill ^ 8'($urandom_range(1, 255)), 8'($urandom),
                       {4'($urandom), 4'h0}, 4'($urandom));
        queue_random_frames(170);
        wait_drained();

        // High extremes
        apply_settings(8'h00, 8'hFF, 8'hFF, 8'hF0, 4'd15);
        queue_random_frames(160);
        wait_drained();

        // Low extremes: no escape mask, no LLC header
        apply_settings(8'hFF, 8'h00, 8'h00, 8'h00, 4'd0);
        queue_random_frames(160);
        wait_drained();

        // Flag and escape equal: frames cannot close, escapes may stay pending
        apply_settings(8'h55, 8'h55, 8'($urandom), hmfd_pkg::FORMAT_RESET,
                       hmfd_pkg::LLC_RESET);
        queue_random_frames(60);
        wait_drained();

        // Back to the reset values
        apply_settings(hmfd_pkg::FLAG_RESET, hmfd_pkg::ESCAPE_RESET, hmfd_pkg::MASK_RESET,
                       hmfd_pkg::FORMAT_RESET, hmfd_pkg::LLC_RESET);
        queue_random_frames(130);
        wait_drained();

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/hmfd_pkg.sv
rtl/core/hmfd_parser.sv
rtl/core/hdlc_meter_frame_decoder_unit.sv
tb/tb.sv
